FILE: rtl/qple_pkg.sv
// Shared types, character codes and token encoding for the quoted-printable line encoder.
package qple_pkg;

  typedef logic [7:0] char_t;

  localparam char_t CH_NL  = 8'h0A;
  localparam char_t CH_TAB = 8'h09;
  localparam char_t CH_SP  = 8'h20;
  localparam char_t CH_DOT = 8'h2E;
  localparam char_t CH_EQ  = 8'h3D;

  localparam logic [9:0] LIMIT_MIN = 10'd8;
  localparam logic [9:0] LIMIT_MAX = 10'd1000;
  localparam logic [9:0] LIMIT_RST = 10'd990;

  // Register index decoded from the configuration address.
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  // One input byte with its class, as held in the front queue.
  typedef struct packed {
    char_t b;
    logic  is_ws;
    logic  is_tab;
    logic  is_nl;
    logic  is_dot;
  } qple_item_t;

  // Characters handed from the sequencer to the output packer in one cycle.
  typedef struct packed {
    logic        valid;
    logic        eos;
    logic [1:0]  n;
    logic [23:0] chars;
  } qple_app_t;

  typedef struct packed {
    logic [23:0] chars;
    logic [1:0]  n;
  } qple_emit_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRD,
    ST_TOK,
    ST_BRK,
    ST_LIST,
    ST_DRD,
    ST_DCH,
    ST_DSH,
    ST_RAW
  } qple_state_t;

  function automatic char_t hex_digit(input logic [3:0] v);
    char_t c;
    if (v < 4'd10) c = {4'h3, v};
    else c = 8'h37 + {4'h0, v};
    return c;
  endfunction

  // Plain character, or =XX for '=', controls, high bytes and encoded whitespace.
  function automatic qple_emit_t emit_token(input char_t tok, input logic enc);
    logic       ws;
    logic       hex;
    qple_emit_t e;
    ws  = (tok == CH_SP) || (tok == CH_TAB);
    hex = (tok == CH_EQ) || (ws && enc) ||
          (!ws && (tok != CH_NL) && ((tok < 8'h20) || (tok > 8'h7E)));
    if (hex) begin
      e.chars = {hex_digit(tok[3:0]), hex_digit(tok[7:4]), CH_EQ};
      e.n     = 2'd3;
    end else begin
      e.chars = {16'h0000, tok};
      e.n     = 2'd1;
    end
    return e;
  endfunction

endpackage

FILE: rtl/qple_ram.sv
// Generic single-port-write, registered-read RAM.
module qple_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/qple_front.sv
// Input side: classifies accepted bytes and queues them for the sequencer.
module qple_front
  import qple_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  char_t      in_byte,
  output logic       q_valid,
  output qple_item_t q_item,
  input  logic       q_pop
);

  qple_item_t [1:0] ent_r;
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             push;
  qple_item_t       cls;

  always_comb begin
    cls.b      = in_byte;
    cls.is_tab = (in_byte == CH_TAB);
    cls.is_ws  = (in_byte == CH_TAB) || (in_byte == CH_SP);
    cls.is_nl  = (in_byte == CH_NL);
    cls.is_dot = (in_byte == CH_DOT);
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cls;
    end
  end

endmodule

FILE: rtl/qple_back.sv
// Sequencer: whitespace holding, soft-break splitting and per-token character generation.
module qple_back
  import qple_pkg::*;
#(
  parameter int WS_HOLD_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  qple_item_t                       q_item,
  output logic                             q_pop,
  input  logic                             enc_en,
  input  logic [9:0]                       line_limit,
  input  logic                             pk_ready,
  output qple_app_t                        app,
  output logic                             ram_we,
  output logic [$clog2(WS_HOLD_DEPTH)-1:0] ram_waddr,
  output logic                             ram_wdata,
  output logic [$clog2(WS_HOLD_DEPTH)-1:0] ram_raddr,
  input  logic                             ram_rdata
);

  localparam int AW = $clog2(WS_HOLD_DEPTH);
  localparam int CW = $clog2(WS_HOLD_DEPTH + 1);
  localparam logic [CW-1:0] WS_FULL = CW'(WS_HOLD_DEPTH);

  qple_state_t       state_r, state_nxt;
  qple_item_t        item_r, item_nxt;
  logic              at_ls_r, at_ls_nxt;
  logic              dotted_r, dotted_nxt;
  logic [CW-1:0]     ws_cnt_r, ws_cnt_nxt;
  logic [CW-1:0]     fidx_r, fidx_nxt;
  logic              fenc_r, fenc_nxt;
  logic              fin_write_r, fin_write_nxt;
  logic              from_ws_r, from_ws_nxt;
  logic              pending_r, pending_nxt;
  logic [1:0]        shc_r, shc_nxt;
  char_t [1:0]       sh_tok_r, sh_tok_nxt;
  logic [1:0]        sh_enc_r, sh_enc_nxt;
  logic [9:0]        chunk_pos_r, chunk_pos_nxt;
  char_t             cur_tok_r, cur_tok_nxt;
  logic              cur_enc_r, cur_enc_nxt;
  logic [1:0]        li_r, li_nxt;
  logic [1:0]        list_n_r, list_n_nxt;

  logic [9:0]        lim;
  logic [9:0]        chunk_len;
  logic [9:0]        cp_inc;
  char_t             ws_char;
  char_t             tok_in;
  logic              enc_in;
  logic              li_last;
  char_t             adv_tok;
  logic              adv_enc;
  qple_emit_t        adv_emit;
  logic [9:0]        cp_adv;
  logic              set_pend;
  logic [1:0]        need;
  logic [1:0]        split_n;
  logic              split_hold;
  logic              split_brk;
  logic              tok_done;
  logic [CW-1:0]     nxt_idx;
  logic              more_ws;
  logic              fl_more;
  logic              done_item;
  logic              step;
  logic              idle_ws_store;
  logic              raw_dot;

  // Shared decode of the current token and split decision.
  always_comb begin
    if (line_limit < LIMIT_MIN) lim = LIMIT_MIN;
    else if (line_limit > LIMIT_MAX) lim = LIMIT_MAX;
    else lim = line_limit;
    chunk_len = lim - 10'd2 - {9'd0, dotted_r};

    ws_char = ram_rdata ? CH_TAB : CH_SP;
    tok_in  = from_ws_r ? ws_char : item_r.b;
    enc_in  = from_ws_r && fenc_r;
    li_last = (li_r == list_n_r - 2'd1);

    unique case (state_r)
      ST_LIST: begin
        adv_tok = li_last ? cur_tok_r : sh_tok_r[li_r[0]];
        adv_enc = li_last ? cur_enc_r : sh_enc_r[li_r[0]];
      end
      ST_DSH: begin
        adv_tok = sh_tok_r[li_r[0]];
        adv_enc = sh_enc_r[li_r[0]];
      end
      ST_DCH: begin
        adv_tok = ws_char;
        adv_enc = 1'b0;
      end
      default: begin
        adv_tok = tok_in;
        adv_enc = enc_in;
      end
    endcase
    adv_emit = emit_token(adv_tok, adv_enc);

    cp_inc   = chunk_pos_r + 10'd1;
    cp_adv   = (adv_tok == CH_NL) ? 10'd0 : cp_inc;
    set_pend = (adv_tok != CH_NL) && (cp_inc >= chunk_len);

    need       = dotted_r ? 2'd3 : 2'd2;
    split_n    = shc_r + 2'd1;
    split_hold = (tok_in != CH_NL) && (split_n < need);
    split_brk  = (split_n >= need);

    tok_done = ((state_r == ST_TOK) && (!pending_r || split_hold)) ||
               ((state_r == ST_LIST) && li_last);
    nxt_idx   = fidx_r + CW'(1);
    more_ws   = (nxt_idx < ws_cnt_r);
    fl_more   = from_ws_r && more_ws;
    done_item = tok_done && (!from_ws_r || (!more_ws && fin_write_r));

    q_pop         = (state_r == ST_IDLE) && q_valid && pk_ready;
    step          = (state_r != ST_IDLE) && pk_ready;
    idle_ws_store = enc_en && q_item.is_ws && (ws_cnt_r != WS_FULL);
    raw_dot       = at_ls_r && item_r.is_dot;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          if (!enc_en) begin
            if (ws_cnt_r != '0) state_nxt = ST_DRD;
            else if (shc_r != 2'd0) state_nxt = ST_DSH;
            else state_nxt = ST_RAW;
          end else if (idle_ws_store) begin
            state_nxt = ST_IDLE;
          end else if (ws_cnt_r != '0) begin
            state_nxt = ST_FRD;
          end else begin
            state_nxt = ST_TOK;
          end
        end
      end
      ST_FRD: begin
        if (pk_ready) state_nxt = ST_TOK;
      end
      ST_TOK, ST_LIST: begin
        if (pk_ready) begin
          if (state_r == ST_TOK && pending_r && !split_hold) begin
            state_nxt = split_brk ? ST_BRK : ST_LIST;
          end else if (tok_done) begin
            if (!from_ws_r) state_nxt = ST_IDLE;
            else if (more_ws) state_nxt = ST_FRD;
            else if (fin_write_r) state_nxt = ST_IDLE;
            else state_nxt = ST_TOK;
          end
        end
      end
      ST_BRK: begin
        if (pk_ready) state_nxt = ST_LIST;
      end
      ST_DRD: begin
        if (pk_ready) state_nxt = ST_DCH;
      end
      ST_DCH: begin
        if (pk_ready) begin
          if (more_ws) state_nxt = ST_DRD;
          else if (shc_r != 2'd0) state_nxt = ST_DSH;
          else state_nxt = ST_RAW;
        end
      end
      ST_DSH: begin
        if (pk_ready && (li_r + 2'd1 == shc_r)) state_nxt = ST_RAW;
      end
      ST_RAW: begin
        if (pk_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates and outputs.
  always_comb begin
    item_nxt      = item_r;
    at_ls_nxt     = at_ls_r;
    dotted_nxt    = dotted_r;
    ws_cnt_nxt    = ws_cnt_r;
    fidx_nxt      = fidx_r;
    fenc_nxt      = fenc_r;
    fin_write_nxt = fin_write_r;
    from_ws_nxt   = from_ws_r;
    pending_nxt   = pending_r;
    shc_nxt       = shc_r;
    sh_tok_nxt    = sh_tok_r;
    sh_enc_nxt    = sh_enc_r;
    chunk_pos_nxt = chunk_pos_r;
    cur_tok_nxt   = cur_tok_r;
    cur_enc_nxt   = cur_enc_r;
    li_nxt        = li_r;
    list_n_nxt    = list_n_r;
    app           = '0;
    ram_we        = 1'b0;
    ram_waddr     = ws_cnt_r[AW-1:0];
    ram_wdata     = q_item.is_tab;
    ram_raddr     = fidx_r[AW-1:0];

    if (q_pop) begin
      item_nxt  = q_item;
      app.valid = 1'b1;
      fidx_nxt  = '0;
      li_nxt    = 2'd0;
      if (enc_en) begin
        if (at_ls_r && q_item.is_dot) begin
          app.n      = 2'd1;
          app.chars  = {16'h0000, CH_DOT};
          dotted_nxt = 1'b1;
        end
        if (idle_ws_store) begin
          ram_we     = 1'b1;
          ws_cnt_nxt = ws_cnt_r + CW'(1);
          app.eos    = 1'b1;
          at_ls_nxt  = 1'b0;
        end else begin
          fenc_nxt      = q_item.is_nl || q_item.is_ws;
          fin_write_nxt = q_item.is_ws;
          from_ws_nxt   = (ws_cnt_r != '0);
        end
      end
    end

    if (step) begin
      app.valid = 1'b1;
      unique case (state_r)
        ST_TOK: begin
          if (!pending_r) begin
            app.n         = adv_emit.n;
            app.chars     = adv_emit.chars;
            chunk_pos_nxt = cp_adv;
            pending_nxt   = set_pend;
          end else if (split_hold) begin
            sh_tok_nxt[shc_r[0]] = tok_in;
            sh_enc_nxt[shc_r[0]] = enc_in;
            shc_nxt              = split_n;
          end else begin
            cur_tok_nxt   = tok_in;
            cur_enc_nxt   = enc_in;
            li_nxt        = 2'd0;
            list_n_nxt    = split_n;
            pending_nxt   = 1'b0;
            shc_nxt       = 2'd0;
            chunk_pos_nxt = 10'd0;
          end
        end
        ST_BRK: begin
          app.n     = 2'd2;
          app.chars = {8'h00, CH_NL, CH_EQ};
        end
        ST_LIST: begin
          app.n         = adv_emit.n;
          app.chars     = adv_emit.chars;
          chunk_pos_nxt = cp_adv;
          pending_nxt   = pending_r || set_pend;
          li_nxt        = li_r + 2'd1;
        end
        ST_DCH: begin
          app.n     = adv_emit.n;
          app.chars = adv_emit.chars;
          fidx_nxt  = nxt_idx;
          if (!more_ws) ws_cnt_nxt = '0;
        end
        ST_DSH: begin
          app.n     = adv_emit.n;
          app.chars = adv_emit.chars;
          li_nxt    = li_r + 2'd1;
        end
        ST_RAW: begin
          app.eos       = 1'b1;
          app.n         = raw_dot ? 2'd2 : 2'd1;
          app.chars     = raw_dot ? {8'h00, item_r.b, CH_DOT} : {16'h0000, item_r.b};
          shc_nxt       = 2'd0;
          pending_nxt   = 1'b0;
          chunk_pos_nxt = 10'd0;
          at_ls_nxt     = item_r.is_nl;
          if (raw_dot) dotted_nxt = 1'b1;
          if (item_r.is_nl) dotted_nxt = 1'b0;
        end
        default: begin
          app.n = 2'd0;
        end
      endcase

      // Close one token: continue the whitespace flush or finish the byte.
      if (tok_done) begin
        if (from_ws_r) begin
          fidx_nxt = nxt_idx;
          if (!fl_more) begin
            ws_cnt_nxt = '0;
            if (fin_write_r) begin
              ram_we     = 1'b1;
              ram_waddr  = '0;
              ram_wdata  = item_r.is_tab;
              ws_cnt_nxt = CW'(1);
            end else begin
              from_ws_nxt = 1'b0;
            end
          end
        end
        if (done_item) begin
          app.eos   = 1'b1;
          at_ls_nxt = item_r.is_nl;
          if (item_r.is_nl) dotted_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      at_ls_r     <= 1'b1;
      dotted_r    <= 1'b0;
      ws_cnt_r    <= '0;
      fidx_r      <= '0;
      fenc_r      <= 1'b0;
      fin_write_r <= 1'b0;
      from_ws_r   <= 1'b0;
      pending_r   <= 1'b0;
      shc_r       <= 2'd0;
      chunk_pos_r <= 10'd0;
      li_r        <= 2'd0;
      list_n_r    <= 2'd1;
    end else begin
      state_r     <= state_nxt;
      at_ls_r     <= at_ls_nxt;
      dotted_r    <= dotted_nxt;
      ws_cnt_r    <= ws_cnt_nxt;
      fidx_r      <= fidx_nxt;
      fenc_r      <= fenc_nxt;
      fin_write_r <= fin_write_nxt;
      from_ws_r   <= from_ws_nxt;
      pending_r   <= pending_nxt;
      shc_r       <= shc_nxt;
      chunk_pos_r <= chunk_pos_nxt;
      li_r        <= li_nxt;
      list_n_r    <= list_n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    sh_tok_r  <= sh_tok_nxt;
    sh_enc_r  <= sh_enc_nxt;
    cur_tok_r <= cur_tok_nxt;
    cur_enc_r <= cur_enc_nxt;
  end

endmodule

FILE: rtl/qple_pack.sv
// Output packer: groups characters three to a result and drives the result register.
module qple_pack
  import qple_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  qple_app_t   app,
  output logic        pk_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_chars,
  output logic [1:0]  out_count,
  output logic        out_last
);

  logic [47:0] buf_r, buf_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic        eos_r, eos_nxt;
  logic        out_valid_r;
  logic [23:0] out_chars_r;
  logic [1:0]  out_count_r;
  logic        out_last_r;

  logic        slot_free;
  logic        move;
  logic [2:0]  mv_n;
  logic        mv_last;
  logic        clearing;
  logic [2:0]  pend_mid;
  logic [47:0] buf_mid;

  always_comb begin
    slot_free = !out_valid_r || !out_stall;
    // Hold a full group until more follows or the byte ends, so last lands right.
    move      = slot_free && ((pend_r >= 3'd4) || (eos_r && (pend_r != 3'd0)));
    mv_n      = (pend_r >= 3'd3) ? 3'd3 : pend_r;
    mv_last   = eos_r && (pend_r <= 3'd3);
    clearing  = move && mv_last;
    pend_mid  = move ? (pend_r - mv_n) : pend_r;
    buf_mid   = move ? (buf_r >> 24) : buf_r;
    pk_ready  = (pend_mid <= 3'd3) && (!eos_r || clearing);

    buf_nxt  = buf_mid;
    pend_nxt = pend_mid;
    eos_nxt  = eos_r && !clearing;
    if (app.valid) begin
      buf_nxt  = buf_mid | ({24'h000000, app.chars} << {pend_mid[1:0], 3'b000});
      pend_nxt = pend_mid + {1'b0, app.n};
      if (app.eos) eos_nxt = (pend_nxt != 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 3'd0;
      eos_r       <= 1'b0;
      buf_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      eos_r  <= eos_nxt;
      buf_r  <= buf_nxt;
      if (move) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_chars_r <= buf_r[23:0];
      out_count_r <= mv_n[1:0];
      out_last_r  <= mv_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_chars = out_chars_r;
  assign out_count = out_count_r;
  assign out_last  = out_last_r;

endmodule

FILE: rtl/quoted_printable_line_encoder.sv
// Quoted-printable body encoder with dot-stuffing: top level and register file.
//
// Input channel: one body byte per request on in_byte (in_valid / in_stall); newline ends a line.
// Result channel: out_chars carries up to three characters, first in the low byte, out_count
// says how many, out_last marks the final result of an input byte. A byte that is only held
// (whitespace waiting for the rest of its line) produces no result.
// Config: encode_enable at address 0, line_limit at address 4, written over the APB port
// while the block is idle; pready is always high.
// An ordinary byte takes the sequencer's pop step and token step; no new byte is popped until
// the sequencer is idle again. Flushing held whitespace adds a memory read and a token step
// per held byte, and a soft break adds a break step and a list step per carried token. A byte's
// first result passes the queue, item register, packer buffer and result register; a flush delays it.
// A two-entry queue decouples the input from the sequencer; the input stalls only when it
// is full. When the receiver stalls, the result register holds, the packer fills and the
// sequencer then waits.
// Reset (synchronous, rst_n low) empties the queue, packer and held run, sets line start,
// enables encoding and sets line_limit to 990.
module quoted_printable_line_encoder
  import qple_pkg::*;
#(
  parameter int WS_HOLD_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_chars,
  output logic [1:0]  out_count,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(WS_HOLD_DEPTH);

  logic       enable_r;
  logic [9:0] limit_r;
  logic       cfg_wr;

  logic       q_valid;
  qple_item_t q_item;
  logic       q_pop;
  logic       pk_ready;
  qple_app_t  app;
  logic       ram_we;
  logic [AW-1:0] ram_waddr;
  logic       ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic       ram_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      limit_r  <= LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ENABLE: enable_r <= pwdata[0];
        REG_LIMIT:  limit_r  <= pwdata[9:0];
        default:    enable_r <= enable_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ENABLE: prdata = {31'd0, enable_r};
      REG_LIMIT:  prdata = {22'd0, limit_r};
      default:    prdata = '0;
    endcase
  end

  qple_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  qple_ram #(
    .WIDTH (1),
    .DEPTH (WS_HOLD_DEPTH)
  ) u_ws_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  qple_back #(
    .WS_HOLD_DEPTH (WS_HOLD_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .enc_en     (enable_r),
    .line_limit (limit_r),
    .pk_ready   (pk_ready),
    .app        (app),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  qple_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .app       (app),
    .pk_ready  (pk_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_chars (out_chars),
    .out_count (out_count),
    .out_last  (out_last)
  );

endmodule

FILE: rtl/qple_checker.sv
// Port-level checks on the encoder's result channel, bound to the top level.
module qple_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] out_chars,
  input logic [1:0]  out_count,
  input logic        out_last,
  input logic        pready
);

  // Only the final result of a byte may be short.
  a_full_unless_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_count == 2'd3)
    else $error("non-final result with fewer than three characters");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count != 2'd0)
    else $error("result with no characters");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_count == 2'd1 || out_count == 2'd2) |->
      out_chars[23:16] == 8'h00 && (out_count == 2'd2 || out_chars[15:8] == 8'h00))
    else $error("unused result characters not zero");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_chars) && $stable(out_count)
      && $stable(out_last))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind quoted_printable_line_encoder qple_checker u_qple_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_chars (out_chars),
  .out_count (out_count),
  .out_last  (out_last),
  .pready    (pready)
);
